FILE: rtl/cpmdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmdc_pkg
// shared types, constants and the month length table for the cp/m date
// converter
// ----------------------------------------------------------------------------
package cpmdc_pkg;

  localparam int DaysPerQuad     = 1461;
  localparam int DaysFrom76To78  = 730;
  localparam int DaysPerYear     = 365;
  localparam int BaseYear        = 76;
  localparam int FirstCpmYear    = 78;
  localparam int QuoW            = 6;
  // floor(d / 1461) = (d * 91868) >> 27, exact for every 17-bit d below 94519
  localparam logic [16:0] QuadRecip      = 17'd91868;
  localparam int          QuadRecipShift = 27;

  localparam logic KindToCount  = 1'b0;
  localparam logic KindToFields = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  year_in;
    logic [8:0]  day_of_year_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
    logic [15:0] day_count_in;
    logic [15:0] time_word_in;
  } req_t;

  typedef struct packed {
    logic [15:0] day_count_out;
    logic [15:0] time_word_out;
    logic [8:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div_quo;
    logic div_rem;
    logic split;
    logic walk;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/cpmdc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmdc_dp
// datapath: request latch, day count arithmetic, reciprocal divide by days per
// quad, year split, month walk and the result register
// ----------------------------------------------------------------------------
module cpmdc_dp (
  input  logic                   clk,
  input  cpmdc_pkg::req_t        req,
  input  cpmdc_pkg::dp_cmd_t     cmd,
  output cpmdc_pkg::dp_status_t  status,
  output cpmdc_pkg::rsp_t        rsp
);
  import cpmdc_pkg::*;

  logic            kind;
  logic [7:0]      year_in;
  logic [8:0]      yday;
  logic [4:0]      hour_in;
  logic [5:0]      minute_in;
  logic [5:0]      second_in;
  logic [15:0]     time_word;
  logic [16:0]     rem;
  logic [QuoW-1:0] quo;
  logic            leap;
  logic [8:0]      year_r;
  logic [8:0]      day_rem;
  logic [3:0]      month_idx;

  logic [33:0] recip_prod;
  logic [16:0] quad_floor;
  logic        split_leap;
  logic [10:0] r1;
  logic [1:0]  yoff;
  logic [10:0] yoff_days;
  logic [4:0]  mlen;
  logic        walk_done;
  logic [7:0]  year_diff;
  logic [5:0]  quads;
  logic [16:0] quad_days;
  logic [10:0] in_quad_days;
  logic [17:0] count_sum;
  rsp_t        rsp_next;

  // quotient by reciprocal multiply, remainder in the following cycle
  always_comb begin
    recip_prod = 34'(rem) * 34'(QuadRecip);
    quad_floor = 17'(quo) * 17'(DaysPerQuad);
  end

  // split the remainder within a quad into year offset and day of year
  always_comb begin
    split_leap = rem < 17'd366;
    r1         = rem[10:0] - 11'd1;
    priority if (r1 >= 11'(3 * DaysPerYear)) begin
      yoff = 2'd3;
    end else if (r1 >= 11'(2 * DaysPerYear)) begin
      yoff = 2'd2;
    end else if (r1 >= 11'(DaysPerYear)) begin
      yoff = 2'd1;
    end else begin
      yoff = 2'd0;
    end
    unique case (yoff)
      2'd0: yoff_days = 11'd0;
      2'd1: yoff_days = 11'(DaysPerYear);
      2'd2: yoff_days = 11'(2 * DaysPerYear);
      2'd3: yoff_days = 11'(3 * DaysPerYear);
    endcase
  end

  always_comb begin
    mlen             = month_len(month_idx, leap);
    walk_done        = day_rem < {4'd0, mlen};
    status.walk_done = walk_done;
  end

  // day count from year and day of year
  always_comb begin
    year_diff    = year_in - 8'(BaseYear);
    quads        = year_diff[7:2];
    quad_days    = 17'(quads) * 17'(DaysPerQuad);
    unique case (year_in[1:0])
      2'd0: in_quad_days = 11'd0;
      2'd1: in_quad_days = 11'(DaysPerYear + 1);
      2'd2: in_quad_days = 11'(2 * DaysPerYear + 1);
      2'd3: in_quad_days = 11'(3 * DaysPerYear + 1);
    endcase
    count_sum = 18'(in_quad_days) + 18'(yday) + 18'(quad_days) - 18'(DaysFrom76To78);
  end

  always_comb begin
    rsp_next = '0;
    if (kind == KindToCount) begin
      rsp_next.day_count_out = (year_in < 8'(FirstCpmYear)) ? 16'd0 : count_sum[15:0];
      rsp_next.time_word_out = {hour_in, minute_in, second_in[5:1]};
    end else begin
      rsp_next.year_out   = year_r;
      rsp_next.month_out  = month_idx + 4'd1;
      rsp_next.day_out    = day_rem[4:0] + 5'd1;
      rsp_next.hour_out   = time_word[15:11];
      rsp_next.minute_out = time_word[10:5];
      rsp_next.second_out = {time_word[4:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind      <= req.kind;
      year_in   <= req.year_in;
      yday      <= req.day_of_year_in;
      hour_in   <= req.hour_in;
      minute_in <= req.minute_in;
      second_in <= req.second_in;
      time_word <= req.time_word_in;
      rem       <= 17'(req.day_count_in) + 17'(DaysFrom76To78);
    end
    if (cmd.div_quo) begin
      quo <= recip_prod[QuadRecipShift +: QuoW];
    end
    if (cmd.div_rem) begin
      rem <= rem - quad_floor;
    end
    if (cmd.split) begin
      leap      <= split_leap;
      day_rem   <= split_leap ? rem[8:0] : 9'(r1 - yoff_days);
      year_r    <= 9'({quo, 2'b00}) + 9'(BaseYear) + (split_leap ? 9'd0 : 9'(yoff));
      month_idx <= 4'd0;
    end
    if (cmd.walk && !walk_done) begin
      day_rem   <= day_rem - {4'd0, mlen};
      month_idx <= month_idx + 4'd1;
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: rtl/cpmdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmdc_ctrl
// sequencer: accepts a transaction, steps the divide, split and month walk for
// calendar requests, and hands the result to the output register
// ----------------------------------------------------------------------------
module cpmdc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_kind,
  output logic                   req_stall,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  input  cpmdc_pkg::dp_status_t  status,
  output cpmdc_pkg::dp_cmd_t     cmd
);
  import cpmdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_SPLIT,
    S_WALK,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  always_comb begin
    out_free     = !rsp_valid || !rsp_stall;
    req_stall    = state != S_IDLE;
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.div_quo  = state == S_DIV;
    cmd.div_rem  = state == S_REM;
    cmd.split    = state == S_SPLIT;
    cmd.walk     = state == S_WALK;
    cmd.finish   = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req_kind == KindToFields) ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          state <= S_REM;
        end
        S_REM: begin
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (status.walk_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cpm_day_count_date_convert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_day_count_date_convert_core
// converts between cp/m day counts with dos time words and calendar fields
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------
//   request | req_valid | req_stall | req  (cpmdc_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp  (cpmdc_pkg::rsp_t)
//
// a day count request (kind 0) goes from the request latch to the result
// register; a calendar request (kind 1) first passes the reciprocal divide
// by days per quad, the year split and the month walk
// one transaction is in flight at a time; the next is taken once the result
// sits in the output register, which holds it for as long as rsp_stall is high
// synchronous reset clears the sequencer and the result valid
// ----------------------------------------------------------------------------
module cpm_day_count_date_convert_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  cpmdc_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output cpmdc_pkg::rsp_t  rsp
);
  import cpmdc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cpmdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cpmdc_dp u_dp (
    .clk    (clk),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule
